// ===== rtl/rvbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvbc_pkg
// Types, codes and constants shared by the vertex rotation block.
// ----------------------------------------------------------------------------
package rvbc_pkg;

	// Width of one coordinate and of one rotation coefficient
	localparam int CoordWidth = 32;
	localparam int CoefWidth = 16;
	localparam int CoefFracBits = 14;

	// Depth of the queue between front and back
	localparam int QueueDepth = 4;

	// Width of the configuration register index
	localparam int CfgIndexWidth = 3;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_MEASURE = 2'd0,
		OP_TRANSFORM = 2'd1,
		OP_CLEAR = 2'd2
	} op_e;

	// Configuration register indexes
	typedef enum logic [CfgIndexWidth-1:0] {
		REG_COS_PITCH = 3'd0,
		REG_SIN_PITCH = 3'd1,
		REG_COS_YAW = 3'd2,
		REG_SIN_YAW = 3'd3,
		REG_COS_ROLL = 3'd4,
		REG_SIN_ROLL = 3'd5
	} reg_idx_e;

	// Coefficient reset values (Q2.14)
	localparam logic signed [CoefWidth-1:0] CoefOne = 16'sd16384;
	localparam logic signed [CoefWidth-1:0] CoefZero = 16'sd0;

	// Input request
	typedef struct packed {
		op_e op;
		logic signed [CoordWidth-1:0] vertex_x;
		logic signed [CoordWidth-1:0] vertex_y;
		logic signed [CoordWidth-1:0] vertex_z;
	} vtx_t;

	// Output result
	typedef struct packed {
		logic signed [CoordWidth-1:0] rotated_x;
		logic signed [CoordWidth-1:0] rotated_y;
		logic signed [CoordWidth-1:0] rotated_z;
		logic clipped;
	} rot_t;

	// Three coordinates
	typedef struct packed {
		logic signed [CoordWidth-1:0] x;
		logic signed [CoordWidth-1:0] y;
		logic signed [CoordWidth-1:0] z;
	} vec_t;

	// Queue entry: vertex and the box center seen at acceptance
	typedef struct packed {
		vec_t vertex;
		vec_t center;
	} qent_t;

	// Rotation coefficients
	typedef struct packed {
		logic signed [CoefWidth-1:0] cos_pitch;
		logic signed [CoefWidth-1:0] sin_pitch;
		logic signed [CoefWidth-1:0] cos_yaw;
		logic signed [CoefWidth-1:0] sin_yaw;
		logic signed [CoefWidth-1:0] cos_roll;
		logic signed [CoefWidth-1:0] sin_roll;
	} coef_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage
`default_nettype wire

// ===== rtl/rvbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvbc_front
// Accepts requests, keeps the bounding box and queues transform requests
// together with the box center valid at their acceptance.
// ----------------------------------------------------------------------------
module rvbc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            vtx_valid,
	output logic                 vtx_ready,
	input  wire rvbc_pkg::vtx_t  vtx,
	input  wire rvbc_pkg::qstat_t qstat,
	output logic                 q_push,
	output rvbc_pkg::qent_t      q_wdata
);

	localparam int W = rvbc_pkg::CoordWidth;
	localparam logic signed [W-1:0] CrdMax = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CrdMin = {1'b1, {(W-1){1'b0}}};

	rvbc_pkg::vec_t box_min_q;
	rvbc_pkg::vec_t box_max_q;
	logic box_nonempty_q;
	logic accept;

	// Floor of the midpoint, zero for an empty box
	function automatic logic signed [W-1:0] midpoint(input logic signed [W-1:0] lo,
			input logic signed [W-1:0] hi, input logic nonempty);
		logic signed [W:0] sum;
		sum = (W+1)'(lo) + (W+1)'(hi);
		return nonempty ? sum[W:1] : '0;
	endfunction

	// Take a request whenever the queue has room
	assign vtx_ready = !qstat.full;
	assign accept = vtx_valid && vtx_ready;
	assign q_push = accept && (vtx.op == rvbc_pkg::OP_TRANSFORM);

	// Build the queue entry from the current box
	always_comb begin
		q_wdata.vertex.x = vtx.vertex_x;
		q_wdata.vertex.y = vtx.vertex_y;
		q_wdata.vertex.z = vtx.vertex_z;
		q_wdata.center.x = midpoint(box_min_q.x, box_max_q.x, box_nonempty_q);
		q_wdata.center.y = midpoint(box_min_q.y, box_max_q.y, box_nonempty_q);
		q_wdata.center.z = midpoint(box_min_q.z, box_max_q.z, box_nonempty_q);
	end

	// Extend or clear the box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q <= {CrdMax, CrdMax, CrdMax};
			box_max_q <= {CrdMin, CrdMin, CrdMin};
			box_nonempty_q <= 1'b0;
		end else if (accept) begin
			unique case (vtx.op)
				rvbc_pkg::OP_MEASURE: begin
					if (vtx.vertex_x < box_min_q.x) box_min_q.x <= vtx.vertex_x;
					if (vtx.vertex_y < box_min_q.y) box_min_q.y <= vtx.vertex_y;
					if (vtx.vertex_z < box_min_q.z) box_min_q.z <= vtx.vertex_z;
					if (vtx.vertex_x > box_max_q.x) box_max_q.x <= vtx.vertex_x;
					if (vtx.vertex_y > box_max_q.y) box_max_q.y <= vtx.vertex_y;
					if (vtx.vertex_z > box_max_q.z) box_max_q.z <= vtx.vertex_z;
					box_nonempty_q <= 1'b1;
				end
				rvbc_pkg::OP_CLEAR: begin
					box_min_q <= {CrdMax, CrdMax, CrdMax};
					box_max_q <= {CrdMin, CrdMin, CrdMin};
					box_nonempty_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rvbc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvbc_fifo
// Short queue of transform requests between front and back.
// ----------------------------------------------------------------------------
module rvbc_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rvbc_pkg::qent_t  wdata,
	input  wire logic             pop,
	output rvbc_pkg::qent_t       rdata,
	output rvbc_pkg::qstat_t      qstat
);

	localparam int Depth = rvbc_pkg::QueueDepth;
	localparam int AW = $clog2(Depth);
	localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
	localparam logic [AW:0] DepthCnt = (AW+1)'(Depth);

	rvbc_pkg::qent_t mem_q [Depth];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0] count_q;

	assign qstat.full = (count_q == DepthCnt);
	assign qstat.empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a write");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthCnt) else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== rtl/rvbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvbc_back
// Rotation pipeline: subtract center, yaw, pitch, roll, add center and
// saturate. Products and sums sit in alternate stages.
// ----------------------------------------------------------------------------
module rvbc_back #(
	parameter int COEF_FRAC_BITS = rvbc_pkg::CoefFracBits
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rvbc_pkg::qent_t  q_rdata,
	input  wire rvbc_pkg::qstat_t qstat,
	output logic                  q_pop,
	input  wire rvbc_pkg::coef_t  coef,
	output logic                  rot_valid,
	input  wire logic             rot_ready,
	output rvbc_pkg::rot_t        rot
);

	localparam int W = rvbc_pkg::CoordWidth;
	localparam int CW = rvbc_pkg::CoefWidth;
	localparam int F = COEF_FRAC_BITS;
	localparam int NS = 8;
	localparam int D = W + 1;
	localparam int P1 = D + CW;
	localparam int S1 = ((P1 - F) > D ? (P1 - F) : D) + 1;
	localparam int P2 = S1 + CW;
	localparam int S2 = ((P2 - F) > S1 ? (P2 - F) : S1) + 1;
	localparam int P3 = S2 + CW;
	localparam int S3 = ((P3 - F) > S2 ? (P3 - F) : S2) + 1;
	localparam int SF = S3 + 1;
	localparam logic signed [SF-1:0] CrdMax = SF'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SF-1:0] CrdMin = ~CrdMax;

	logic [NS:1] stage_vld_q;
	logic [NS+1:1] adv;

	rvbc_pkg::vec_t ctr_s1, ctr_s2, ctr_s3, ctr_s4, ctr_s5, ctr_s6, ctr_s7;
	logic signed [D-1:0] dx_s1, dy_s1, dz_s1, dy_s2;
	logic signed [P1-1:0] pxc_s2, pzs_s2, pzc_s2, pxs_s2;
	logic signed [S1-1:0] x1_s3, y1_s3, z1_s3, x1_s4;
	logic signed [P2-1:0] pyc_s4, pzs_s4, pys_s4, pzc_s4;
	logic signed [S2-1:0] x1_s5, y2_s5, z2_s5, z2_s6;
	logic signed [P3-1:0] pxc_s6, pys_s6, pxs_s6, pyc_s6;
	logic signed [S3-1:0] x3_s7, y3_s7, z2_s7;
	logic signed [SF-1:0] sum_x, sum_y, sum_z;
	logic clip_x, clip_y, clip_z;
	rvbc_pkg::rot_t rot_s8;

	// Saturate to the coordinate range
	function automatic logic signed [W-1:0] clamp(input logic signed [SF-1:0] v);
		logic signed [SF-1:0] r;
		r = v;
		if (v > CrdMax) r = CrdMax;
		if (v < CrdMin) r = CrdMin;
		return r[W-1:0];
	endfunction

	// A stage loads when it is empty or its content moves on
	always_comb begin
		adv[NS+1] = rot_ready;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !stage_vld_q[k] || adv[k+1];
		end
	end

	assign q_pop = adv[1] && !qstat.empty;
	assign rot_valid = stage_vld_q[NS];
	assign rot = rot_s8;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[1]) stage_vld_q[1] <= !qstat.empty;
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end
	end

	// Stage 1: offset from center
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dx_s1 <= D'(q_rdata.vertex.x) - D'(q_rdata.center.x);
			dy_s1 <= D'(q_rdata.vertex.y) - D'(q_rdata.center.y);
			dz_s1 <= D'(q_rdata.vertex.z) - D'(q_rdata.center.z);
			ctr_s1 <= q_rdata.center;
		end
	end

	// Stage 2: yaw products
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pxc_s2 <= dx_s1 * coef.cos_yaw;
			pzs_s2 <= dz_s1 * coef.sin_yaw;
			pzc_s2 <= dz_s1 * coef.cos_yaw;
			pxs_s2 <= dx_s1 * coef.sin_yaw;
			dy_s2 <= dy_s1;
			ctr_s2 <= ctr_s1;
		end
	end

	// Stage 3: yaw sums, each product floored on its own
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			x1_s3 <= S1'(pxc_s2 >>> F) + S1'(pzs_s2 >>> F);
			z1_s3 <= S1'(pzc_s2 >>> F) - S1'(pxs_s2 >>> F);
			y1_s3 <= S1'(dy_s2);
			ctr_s3 <= ctr_s2;
		end
	end

	// Stage 4: pitch products
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			pyc_s4 <= y1_s3 * coef.cos_pitch;
			pzs_s4 <= z1_s3 * coef.sin_pitch;
			pys_s4 <= y1_s3 * coef.sin_pitch;
			pzc_s4 <= z1_s3 * coef.cos_pitch;
			x1_s4 <= x1_s3;
			ctr_s4 <= ctr_s3;
		end
	end

	// Stage 5: pitch sums
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			y2_s5 <= S2'(pyc_s4 >>> F) - S2'(pzs_s4 >>> F);
			z2_s5 <= S2'(pys_s4 >>> F) + S2'(pzc_s4 >>> F);
			x1_s5 <= S2'(x1_s4);
			ctr_s5 <= ctr_s4;
		end
	end

	// Stage 6: roll products
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			pxc_s6 <= x1_s5 * coef.cos_roll;
			pys_s6 <= y2_s5 * coef.sin_roll;
			pxs_s6 <= x1_s5 * coef.sin_roll;
			pyc_s6 <= y2_s5 * coef.cos_roll;
			z2_s6 <= z2_s5;
			ctr_s6 <= ctr_s5;
		end
	end

	// Stage 7: roll sums
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			x3_s7 <= S3'(pxc_s6 >>> F) - S3'(pys_s6 >>> F);
			y3_s7 <= S3'(pxs_s6 >>> F) + S3'(pyc_s6 >>> F);
			z2_s7 <= S3'(z2_s6);
			ctr_s7 <= ctr_s6;
		end
	end

	// Add center back and detect saturation
	always_comb begin
		sum_x = SF'(x3_s7) + SF'(ctr_s7.x);
		sum_y = SF'(y3_s7) + SF'(ctr_s7.y);
		sum_z = SF'(z2_s7) + SF'(ctr_s7.z);
		clip_x = (sum_x > CrdMax) || (sum_x < CrdMin);
		clip_y = (sum_y > CrdMax) || (sum_y < CrdMin);
		clip_z = (sum_z > CrdMax) || (sum_z < CrdMin);
	end

	// Stage 8: output register
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			rot_s8.rotated_x <= clamp(sum_x);
			rot_s8.rotated_y <= clamp(sum_y);
			rot_s8.rotated_z <= clamp(sum_z);
			rot_s8.clipped <= clip_x || clip_y || clip_z;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rotate_vertices_about_box_center.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_vertices_about_box_center
// Rotates a vertex stream about the center of its bounding box.
// ----------------------------------------------------------------------------
// Send the stream twice: measure requests widen the box, transform requests
// each return one rotated vertex (yaw about Y, pitch about X, roll about Z,
// coefficients in Q2.14, every product floored), clear requests empty the box.
// A request updates the box at the edge that accepts it, so a transform sees
// every measure and clear sent before it. Transforms pass a four-entry queue
// into an eight-stage pipeline that takes one vertex per cycle while the
// output is not stalled. Request ready falls only when the queue is full.
// Write the coefficient registers only while no transform is in flight.
// ----------------------------------------------------------------------------
module rotate_vertices_about_box_center #(
	parameter int COEF_FRAC_BITS = rvbc_pkg::CoefFracBits
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 vtx_valid,
	output logic                                      vtx_ready,
	input  wire rvbc_pkg::vtx_t                       vtx,
	output logic                                      rot_valid,
	input  wire logic                                 rot_ready,
	output rvbc_pkg::rot_t                            rot,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rvbc_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  wire logic [rvbc_pkg::CoefWidth-1:0]       cfg_data
);

	rvbc_pkg::coef_t coef_q;
	rvbc_pkg::qent_t q_wdata;
	rvbc_pkg::qent_t q_rdata;
	rvbc_pkg::qstat_t qstat;
	logic q_push;
	logic q_pop;

	assign cfg_ready = 1'b1;

	// Coefficient registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.cos_pitch <= rvbc_pkg::CoefOne;
			coef_q.sin_pitch <= rvbc_pkg::CoefZero;
			coef_q.cos_yaw <= rvbc_pkg::CoefOne;
			coef_q.sin_yaw <= rvbc_pkg::CoefZero;
			coef_q.cos_roll <= rvbc_pkg::CoefOne;
			coef_q.sin_roll <= rvbc_pkg::CoefZero;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rvbc_pkg::REG_COS_PITCH: coef_q.cos_pitch <= cfg_data;
				rvbc_pkg::REG_SIN_PITCH: coef_q.sin_pitch <= cfg_data;
				rvbc_pkg::REG_COS_YAW: coef_q.cos_yaw <= cfg_data;
				rvbc_pkg::REG_SIN_YAW: coef_q.sin_yaw <= cfg_data;
				rvbc_pkg::REG_COS_ROLL: coef_q.cos_roll <= cfg_data;
				rvbc_pkg::REG_SIN_ROLL: coef_q.sin_roll <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rvbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx),
		.qstat     (qstat),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	rvbc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.qstat  (qstat)
	);

	rvbc_back #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rdata   (q_rdata),
		.qstat     (qstat),
		.q_pop     (q_pop),
		.coef      (coef_q),
		.rot_valid (rot_valid),
		.rot_ready (rot_ready),
		.rot       (rot)
	);

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex rotation block. A directed table covers
// reset behavior, coordinate extremes, clear, ignored requests, floor rounding
// of the box center and saturation; random bursts of measure, transform, clear
// and noise requests follow under several coefficient sets and idle patterns.
// Every result is compared field by field against the table's expected value,
// if given, or else against a local bounding-box and rotation predictor.
// ----------------------------------------------------------------------------
module testbench;
	import rvbc_pkg::*;

	localparam int HalfPeriod = 4;
	localparam int ResetCycles = 10;
	localparam int DrainCycles = 20;
	localparam int CycleLimit = 200000;
	localparam int PhaseCount = 8;
	localparam int PhaseItems = 138;
	localparam int CoefCount = REG_SIN_ROLL + 1;
	localparam int AxisCount = 3;

	// Op code the block drops, and register indexes with no register behind them
	localparam logic [1:0] OpIgnored = 2'd3;
	localparam logic [CfgIndexWidth-1:0] RegSpareA = 3'd6;
	localparam logic [CfgIndexWidth-1:0] RegSpareB = 3'd7;

	localparam logic signed [CoordWidth-1:0] CoordMax = 32'sh7fffffff;
	localparam logic signed [CoordWidth-1:0] CoordMin = 32'sh80000000;

	// Idle patterns: none, sender only, receiver only, both
	localparam int SendIdlePct [4] = '{0, 52, 0, 21};
	localparam int RecvStallPct [4] = '{0, 0, 52, 21};

	typedef logic [CoefWidth-1:0] coef_set_t [CoefCount];

	typedef struct packed {
		logic [1:0] op;
		logic signed [CoordWidth-1:0] x;
		logic signed [CoordWidth-1:0] y;
		logic signed [CoordWidth-1:0] z;
		logic has_want;
		rot_t want;
	} dir_row_t;

	// Directed requests; the coefficient set changes to a half turn of yaw
	// at DirFlipAt, so rows after it mirror x and z about the center
	localparam int DirCount = 23;
	localparam int DirFlipAt = 6;
	localparam dir_row_t DirRows [DirCount] = '{
		'{OP_TRANSFORM, 32'sd5, -32'sd7, 32'sd9, 1'b1, '{32'sd5, -32'sd7, 32'sd9, 1'b0}},
		'{OP_TRANSFORM, CoordMax, CoordMin, 32'sd0, 1'b1, '{CoordMax, CoordMin, 32'sd0, 1'b0}},
		'{OpIgnored, CoordMax, CoordMax, CoordMax, 1'b0, '0},
		'{OP_MEASURE, 32'sd100, -32'sd200, 32'sd300, 1'b0, '0},
		'{OP_TRANSFORM, -32'sd1, -32'sd1, -32'sd1, 1'b1, '{-32'sd1, -32'sd1, -32'sd1, 1'b0}},
		'{OP_CLEAR, 32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
		'{OP_CLEAR, 32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
		'{OP_TRANSFORM, CoordMin, 32'sd5, CoordMin, 1'b1, '{CoordMax, 32'sd5, CoordMax, 1'b1}},
		'{OP_TRANSFORM, CoordMax, -32'sd1, 32'sd0, 1'b1,
			'{-32'sd2147483647, -32'sd1, 32'sd0, 1'b0}},
		'{OP_MEASURE, CoordMin, CoordMin, CoordMin, 1'b0, '0},
		'{OP_MEASURE, CoordMax, CoordMax, CoordMax, 1'b0, '0},
		'{OP_TRANSFORM, 32'sd0, 32'sd0, 32'sd0, 1'b1, '{-32'sd2, 32'sd0, -32'sd2, 1'b0}},
		'{OP_TRANSFORM, CoordMin, 32'sd9, CoordMax, 1'b1,
			'{32'sd2147483646, 32'sd9, CoordMin, 1'b1}},
		'{OP_CLEAR, 32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
		'{OP_MEASURE, 32'sd10, 32'sd10, 32'sd10, 1'b0, '0},
		'{OpIgnored, 32'sd5000, 32'sd5000, 32'sd5000, 1'b0, '0},
		'{OP_MEASURE, 32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
		'{OP_TRANSFORM, 32'sd7, 32'sd3, 32'sd1, 1'b1, '{32'sd3, 32'sd3, 32'sd9, 1'b0}},
		'{OP_MEASURE, -32'sd21, -32'sd21, -32'sd21, 1'b0, '0},
		'{OP_TRANSFORM, 32'sd1, 32'sd1, 32'sd1, 1'b1, '{-32'sd13, 32'sd1, -32'sd13, 1'b0}},
		'{OP_TRANSFORM, 32'sh12345678, -32'sd98765, 32'sh7fff0000, 1'b0, '0},
		'{OP_MEASURE, 32'sh40000000, 32'shc0000000, -32'sd1, 1'b0, '0},
		'{OP_TRANSFORM, 32'sh7ffffff0, 32'sh80000010, 32'sh0badf00d, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic vtx_valid;
	logic vtx_ready;
	vtx_t vtx;
	logic rot_valid;
	logic rot_ready = 1'b0;
	rot_t rot;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CoefWidth-1:0] cfg_data;

	// Predictor state: bounding box and coefficient registers
	logic signed [CoordWidth-1:0] box_lo [AxisCount];
	logic signed [CoordWidth-1:0] box_hi [AxisCount];
	bit box_filled;
	coef_set_t coef_reg;
	logic signed [CoordWidth-1:0] burst_base [AxisCount];

	rot_t rotated_due [$];
	int mismatches = 0;
	int items_taken = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles_run = 0;

	rotate_vertices_about_box_center DUT (
		.clk(clk),
		.arst_n(arst_n),
		.vtx_valid(vtx_valid),
		.vtx_ready(vtx_ready),
		.vtx(vtx),
		.rot_valid(rot_valid),
		.rot_ready(rot_ready),
		.rot(rot),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HalfPeriod clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void empty_box();
		for (int a = 0; a < AxisCount; a++) begin
			box_lo[a] = CoordMax;
			box_hi[a] = CoordMin;
		end
		box_filled = 1'b0;
	endfunction

	// Q2.14 product, floored
	function automatic longint mul_floor(input longint a, input longint c);
		return (a * c) >>> CoefFracBits;
	endfunction

	function automatic logic signed [CoordWidth-1:0] clamp_coord(input longint v,
			inout bit clip);
		if (v > longint'(CoordMax)) begin
			clip = 1'b1;
			return CoordMax;
		end
		if (v < longint'(CoordMin)) begin
			clip = 1'b1;
			return CoordMin;
		end
		return v[CoordWidth-1:0];
	endfunction

	// Apply one request to the box; return 1 with the rotated vertex for a transform
	function automatic bit rotate_about_box(input vtx_t v, output rot_t res);
		logic signed [CoordWidth-1:0] p [AxisCount];
		longint cen [AxisCount];
		longint dif [AxisCount];
		longint cp, sp, cyw, syw, cr, sr;
		longint x1, z1, y2, z2, x3, y3;
		bit clip;
		res = '0;
		p[0] = v.vertex_x;
		p[1] = v.vertex_y;
		p[2] = v.vertex_z;
		case (v.op)
			OP_MEASURE: begin
				for (int a = 0; a < AxisCount; a++) begin
					if (p[a] < box_lo[a]) box_lo[a] = p[a];
					if (p[a] > box_hi[a]) box_hi[a] = p[a];
				end
				box_filled = 1'b1;
				return 1'b0;
			end
			OP_CLEAR: begin
				empty_box();
				return 1'b0;
			end
			OP_TRANSFORM: begin
				// center floors (lo+hi)/2; an empty box centers on zero
				for (int a = 0; a < AxisCount; a++) begin
					cen[a] = box_filled ?
						((longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1) : 0;
					dif[a] = longint'(p[a]) - cen[a];
				end
				cp = longint'($signed(coef_reg[REG_COS_PITCH]));
				sp = longint'($signed(coef_reg[REG_SIN_PITCH]));
				cyw = longint'($signed(coef_reg[REG_COS_YAW]));
				syw = longint'($signed(coef_reg[REG_SIN_YAW]));
				cr = longint'($signed(coef_reg[REG_COS_ROLL]));
				sr = longint'($signed(coef_reg[REG_SIN_ROLL]));
				// yaw about Y, pitch about X, roll about Z
				x1 = mul_floor(dif[0], cyw) + mul_floor(dif[2], syw);
				z1 = mul_floor(dif[2], cyw) - mul_floor(dif[0], syw);
				y2 = mul_floor(dif[1], cp) - mul_floor(z1, sp);
				z2 = mul_floor(dif[1], sp) + mul_floor(z1, cp);
				x3 = mul_floor(x1, cr) - mul_floor(y2, sr);
				y3 = mul_floor(x1, sr) + mul_floor(y2, cr);
				clip = 1'b0;
				res.rotated_x = clamp_coord(x3 + cen[0], clip);
				res.rotated_y = clamp_coord(y3 + cen[1], clip);
				res.rotated_z = clamp_coord(z2 + cen[2], clip);
				res.clipped = clip;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic signed [CoordWidth-1:0] pick_coord();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: return CoordMax;
					1: return CoordMin;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(28, 4);
		endcase
	endfunction

	// Vertex near the current burst base, or anywhere when scatter is set
	function automatic vtx_t make_vertex(input logic [1:0] op, input bit scatter);
		vtx_t v;
		logic signed [CoordWidth-1:0] c [AxisCount];
		for (int a = 0; a < AxisCount; a++)
			c[a] = scatter ? pick_coord() :
				burst_base[a] + ($signed($urandom) >>> $urandom_range(31, 8));
		v.op = op_e'(op);
		v.vertex_x = c[0];
		v.vertex_y = c[1];
		v.vertex_z = c[2];
		return v;
	endfunction

	// Offer one request, hold it until taken, then predict its result
	task automatic send_vertex(input vtx_t v, input bit has_want, input rot_t want);
		rot_t guess;
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx <= v;
		do @(posedge clk); while (!vtx_ready);
		if (rotate_about_box(v, guess))
			rotated_due = {rotated_due, (has_want ? want : guess)};
		if (v.op != OpIgnored)
			items_taken++;
	endtask

	// Drop valid and hold until every pending result has come back
	task automatic wait_results_drained(input int extra);
		vtx_valid <= 1'b0;
		do @(posedge clk); while (rotated_due.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Write all six coefficients, then one write to an unused index
	task automatic load_registers(input coef_set_t vals);
		for (int i = REG_COS_PITCH; i <= REG_SIN_ROLL; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_e'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			coef_reg[i] = vals[i];
		end
		cfg_index <= $urandom_range(1) ? RegSpareA : RegSpareB;
		cfg_data <= CoefWidth'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_coefs(input int kind, output coef_set_t vals);
		for (int i = 0; i < CoefCount; i++) begin
			case (kind)
				0: begin
					case ($urandom_range(2))
						0: vals[i] = -CoefOne;
						1: vals[i] = CoefOne;
						default: vals[i] = CoefZero;
					endcase
				end
				1: vals[i] = 16'($urandom_range(32768) - 16384);
				2: vals[i] = CoefWidth'($urandom);
				default: vals[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
			endcase
		end
	endtask

	// One random burst: mostly clear, measures, transforms; else empty box or noise
	task automatic send_burst();
		int kind;
		int n;
		kind = $urandom_range(9);
		if (kind <= 6) begin
			for (int a = 0; a < AxisCount; a++)
				burst_base[a] = pick_coord();
			if ($urandom_range(3) != 0)
				send_vertex(make_vertex(OP_CLEAR, 1'b1), 1'b0, '0);
			n = $urandom_range(8, 1);
			repeat (n) send_vertex(make_vertex(OP_MEASURE, 1'b0), 1'b0, '0);
			n = $urandom_range(12, 1);
			repeat (n)
				send_vertex(make_vertex(OP_TRANSFORM, $urandom_range(5) == 0), 1'b0, '0);
		end else if (kind == 7) begin
			// transforms against an empty box
			send_vertex(make_vertex(OP_CLEAR, 1'b1), 1'b0, '0);
			n = $urandom_range(3, 1);
			repeat (n) send_vertex(make_vertex(OP_TRANSFORM, 1'b1), 1'b0, '0);
		end else begin
			n = $urandom_range(6, 1);
			repeat (n) send_vertex(make_vertex(2'($urandom_range(3)), 1'b1), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking and receiver stalls
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [CoordWidth-1:0] want,
			input logic [CoordWidth-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch_results
		rot_t want;
		if (rot_valid && rot_ready) begin
			if (rotated_due.size() == 0) begin
				$display("%0t: result with nothing pending, got %h", $time, rot);
				mismatches++;
			end else begin
				want = rotated_due.pop_front();
				check_field("rotated_x", want.rotated_x, rot.rotated_x);
				check_field("rotated_y", want.rotated_y, rot.rotated_y);
				check_field("rotated_z", want.rotated_z, rot.rotated_z);
				check_field("clipped", CoordWidth'(want.clipped), CoordWidth'(rot.clipped));
			end
		end
		rot_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run
	initial begin
		while (cycles_run < CycleLimit) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("%0t: cycle limit reached with %0d results pending", $time,
			rotated_due.size());
		$display("rotate_vertices_about_box_center verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		vtx_t v;
		coef_set_t vals;
		int first;
		bit paused;
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		vtx = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		empty_box();
		// cosines reset to one, sines to zero
		for (int i = REG_COS_PITCH; i <= REG_SIN_ROLL; i++)
			coef_reg[i] = (i % 2 == 0) ? CoefOne : CoefZero;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DirCount; i++) begin
			if (i == DirFlipAt) begin
				wait_results_drained(DrainCycles);
				vals = coef_reg;
				vals[REG_COS_YAW] = -CoefOne;
				load_registers(vals);
			end
			v.op = op_e'(DirRows[i].op);
			v.vertex_x = DirRows[i].x;
			v.vertex_y = DirRows[i].y;
			v.vertex_z = DirRows[i].z;
			send_vertex(v, DirRows[i].has_want, DirRows[i].want);
		end

		// Random phases, each with its own coefficients and idle pattern
		for (int ph = 0; ph < PhaseCount; ph++) begin
			wait_results_drained(DrainCycles);
			fill_coefs((ph + ph / 4) % 4, vals);
			load_registers(vals);
			send_idle_pct = SendIdlePct[ph % 4];
			recv_stall_pct = RecvStallPct[ph % 4];
			first = items_taken;
			paused = 1'b0;
			while (items_taken - first < PhaseItems) begin
				// hold the sender once per phase until the output runs dry
				if (!paused && items_taken - first >= PhaseItems / 2) begin
					wait_results_drained(0);
					paused = 1'b1;
				end
				send_burst();
			end
		end

		wait_results_drained(DrainCycles);
		if (mismatches == 0 && rotated_due.size() == 0)
			$display("rotate_vertices_about_box_center verification clean");
		else
			$display("rotate_vertices_about_box_center verification failed");
		$finish;
	end

endmodule
